// ===== hdl/qrs_pkg.sv =====
// Shared widths, result kinds and the Q16.16 clamp for the quadratic root solver.
package qrs_pkg;

    localparam int CoefW  = 16;
    localparam int RadW   = 50;
    localparam int RootW  = RadW / 2;
    localparam int NumW   = 33;
    localparam int DenW   = 16;
    localparam int ValW   = 32;
    localparam int KindW  = 2;
    localparam int SSideW = CoefW + CoefW + KindW;
    localparam int DSideW = KindW + 1;

    typedef enum logic [KindW-1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_INVALID  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       sat;
        logic [ValW-1:0] val;
    } qval_t;

    function automatic qval_t clamp_q(input logic neg, input logic [NumW-1:0] mag);
        qval_t r;
        r.sat = 1'b0;
        if (!neg) begin
            if (mag[NumW-1:ValW-1] != '0) begin
                r.sat = 1'b1;
                r.val = {1'b0, {(ValW-1){1'b1}}};
            end else begin
                r.val = mag[ValW-1:0];
            end
        end else begin
            if (mag[NumW-1:ValW] != '0 || (mag[ValW-1] && mag[ValW-2:0] != '0)) begin
                r.sat = 1'b1;
                r.val = {1'b1, {(ValW-1){1'b0}}};
            end else begin
                r.val = ValW'(~mag[ValW-1:0] + 1'b1);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/qrs_sqrt_pipe.sv =====
// Pipelined floor square root, one root bit per register stage, with side data.
module qrs_sqrt_pipe #(
    parameter int RAD_W  = qrs_pkg::RadW,
    parameter int SIDE_W = qrs_pkg::SSideW
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [RAD_W-1:0]  x_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [RAD_W-1:0]  cur_x;
        logic [REM_W-1:0]  cur_rem;
        logic [ROOT_W-1:0] cur_root;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign cur_x    = in_rad;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_side = in_side;
            assign cur_vld  = in_valid;
        end else begin : g_next
            assign cur_x    = x_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_side = side_reg[k-1];
            assign cur_vld  = vld_reg[k-1];
        end

        assign rem_sh = {cur_rem[REM_W-3:0], cur_x[RAD_W-1 -: 2]};
        assign trial  = {cur_root, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= cur_x << 2;
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {cur_root[ROOT_W-2:0], ge};
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== hdl/qrs_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per register stage, with side data.
module qrs_div_pipe #(
    parameter int NUM_W  = qrs_pkg::NumW,
    parameter int DEN_W  = qrs_pkg::DenW,
    parameter int SIDE_W = qrs_pkg::DSideW
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  quot_reg [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic              vld_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0]  cur_num;
        logic [DEN_W-1:0]  cur_den;
        logic [DEN_W-1:0]  cur_rem;
        logic [NUM_W-1:0]  cur_quot;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;
        logic [DEN_W:0]    rem_sh;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign cur_num  = in_num;
            assign cur_den  = in_den;
            assign cur_rem  = '0;
            assign cur_quot = '0;
            assign cur_side = in_side;
            assign cur_vld  = in_valid;
        end else begin : g_next
            assign cur_num  = num_reg[k-1];
            assign cur_den  = den_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_quot = quot_reg[k-1];
            assign cur_side = side_reg[k-1];
            assign cur_vld  = vld_reg[k-1];
        end

        assign rem_sh = {cur_rem, cur_num[NUM_W-1]};
        assign ge     = (rem_sh >= {1'b0, cur_den});
        assign diff   = rem_sh - {1'b0, cur_den};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k]  <= cur_num << 1;
                den_reg[k]  <= cur_den;
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quot_reg[k] <= {cur_quot[NUM_W-2:0], ge};
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quot  = quot_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

// ===== hdl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: discriminant, square root, division and clamp.
//
// A request on the slave channel carries the Q8.8 coefficients a, b and c of
// a*x^2 + b*x + c. Each request yields exactly one result on the master
// channel: the root kind and saturation flag in m_tuser, and two Q16.16
// values in m_tdata (two real roots, the double root twice, or the real part
// and imaginary magnitude of a complex pair). A zero a gives the invalid kind
// with both values and the flag cleared.
// The pipeline runs through the product and discriminant registers, the square
// root stages (one root bit per stage), the numerator register, the divider
// stages (one quotient bit per stage) and the output register.
// Throughput is one request per cycle unless stalled; every stage holds a valid bit.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready falls, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and the output valid.
module quadratic_root_solver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // first_value [31:0], second_value [63:32]
    output logic [2:0]  m_tuser    // root_kind [1:0], saturated [2]
);

    localparam int CW = qrs_pkg::CoefW;
    localparam int VW = qrs_pkg::ValW;
    localparam int NW = qrs_pkg::NumW;
    localparam int RW = qrs_pkg::RootW;

    logic adv;

    logic                 p1_vld_reg;
    logic signed [CW-1:0] p1_a_reg, p1_b_reg;
    logic signed [31:0]   p1_bb_reg, p1_ac_reg;

    logic                      p2_vld_reg;
    logic [qrs_pkg::RadW-1:0]  p2_rad_reg;
    logic [qrs_pkg::SSideW-1:0] p2_side_reg;

    logic signed [34:0] dq;
    logic [32:0]        dq_mag;
    qrs_pkg::kind_t     kind_next;

    logic                       sq_vld;
    logic [RW-1:0]              sq_root;
    logic [qrs_pkg::SSideW-1:0] sq_side;
    logic signed [CW-1:0]       sq_a, sq_b;
    qrs_pkg::kind_t             sq_kind;

    logic signed [24:0] negb;
    logic signed [26:0] n1, n2;
    logic [25:0]        n1_mag, n2_mag;
    logic               neg1, neg2;

    logic                p3_vld_reg;
    logic [NW-1:0]       p3_num1_reg, p3_num2_reg;
    logic [CW-1:0]       p3_den_reg;
    logic [qrs_pkg::DSideW-1:0] p3_side1_reg;
    logic                p3_neg2_reg;

    logic                       d1_vld, d2_vld;
    logic [NW-1:0]              d1_quot, d2_quot;
    logic [qrs_pkg::DSideW-1:0] d1_side;
    logic                       d2_side;
    qrs_pkg::kind_t             d_kind;
    qrs_pkg::qval_t             v1, v2;

    logic           m_vld_reg;
    logic [VW-1:0]  m_first_reg, m_second_reg;
    logic [1:0]     m_kind_reg;
    logic           m_sat_reg;

    assign adv      = !m_vld_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= s_tvalid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= sq_vld;
            m_vld_reg  <= d1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_a_reg  <= s_tdata[15:0];
            p1_b_reg  <= s_tdata[31:16];
            p1_bb_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
            p1_ac_reg <= $signed(s_tdata[15:0]) * $signed(s_tdata[47:32]);
        end
    end

    assign dq     = 35'(p1_bb_reg) - (35'(p1_ac_reg) <<< 2);
    assign dq_mag = dq[34] ? 33'(-dq) : dq[32:0];

    always_comb begin
        priority if (p1_a_reg == '0) begin
            kind_next = qrs_pkg::KIND_INVALID;
        end else if (dq == '0) begin
            kind_next = qrs_pkg::KIND_DOUBLE;
        end else if (dq[34]) begin
            kind_next = qrs_pkg::KIND_COMPLEX;
        end else begin
            kind_next = qrs_pkg::KIND_TWO_REAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_rad_reg  <= {1'b0, dq_mag, 16'b0};
            p2_side_reg <= {p1_a_reg, p1_b_reg, kind_next};
        end
    end

    qrs_sqrt_pipe #(
        .RAD_W  (qrs_pkg::RadW),
        .SIDE_W (qrs_pkg::SSideW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p2_vld_reg),
        .in_rad    (p2_rad_reg),
        .in_side   (p2_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_a    = sq_side[qrs_pkg::SSideW-1 -: CW];
    assign sq_b    = sq_side[qrs_pkg::KindW +: CW];
    assign sq_kind = qrs_pkg::kind_t'(sq_side[qrs_pkg::KindW-1:0]);
    assign negb    = -(25'(sq_b) <<< 8);

    always_comb begin
        n1 = 27'(negb);
        n2 = 27'(negb);
        unique case (sq_kind)
            qrs_pkg::KIND_TWO_REAL: begin
                n1 = 27'(negb) + 27'(sq_root);
                n2 = 27'(negb) - 27'(sq_root);
            end
            qrs_pkg::KIND_COMPLEX: begin
                n2 = 27'(sq_root);
            end
            default: begin
            end
        endcase
    end

    assign n1_mag = n1[26] ? 26'(-n1) : n1[25:0];
    assign n2_mag = n2[26] ? 26'(-n2) : n2[25:0];
    assign neg1   = n1[26] ^ sq_a[CW-1];
    assign neg2   = (sq_kind == qrs_pkg::KIND_COMPLEX) ? 1'b0 : (n2[26] ^ sq_a[CW-1]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_num1_reg  <= {n1_mag, 7'b0};
            p3_num2_reg  <= {n2_mag, 7'b0};
            p3_den_reg   <= sq_a[CW-1] ? CW'(-sq_a) : sq_a;
            p3_side1_reg <= {neg1, sq_kind};
            p3_neg2_reg  <= neg2;
        end
    end

    qrs_div_pipe #(
        .NUM_W  (NW),
        .DEN_W  (qrs_pkg::DenW),
        .SIDE_W (qrs_pkg::DSideW)
    ) u_div_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p3_vld_reg),
        .in_num    (p3_num1_reg),
        .in_den    (p3_den_reg),
        .in_side   (p3_side1_reg),
        .out_valid (d1_vld),
        .out_quot  (d1_quot),
        .out_side  (d1_side)
    );

    qrs_div_pipe #(
        .NUM_W  (NW),
        .DEN_W  (qrs_pkg::DenW),
        .SIDE_W (1)
    ) u_div_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p3_vld_reg),
        .in_num    (p3_num2_reg),
        .in_den    (p3_den_reg),
        .in_side   (p3_neg2_reg),
        .out_valid (d2_vld),
        .out_quot  (d2_quot),
        .out_side  (d2_side)
    );

    assign d_kind = qrs_pkg::kind_t'(d1_side[qrs_pkg::KindW-1:0]);
    assign v1     = qrs_pkg::clamp_q(d1_side[qrs_pkg::KindW], d1_quot);
    assign v2     = qrs_pkg::clamp_q(d2_side, d2_quot);

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_kind_reg <= d_kind;
            if (d_kind == qrs_pkg::KIND_INVALID) begin
                m_first_reg  <= '0;
                m_second_reg <= '0;
                m_sat_reg    <= 1'b0;
            end else begin
                m_first_reg  <= v1.val;
                m_second_reg <= v2.val;
                m_sat_reg    <= v1.sat | v2.sat;
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {m_second_reg, m_first_reg};
    assign m_tuser  = {m_sat_reg, m_kind_reg};

`ifndef ASSERT_OFF
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        d1_vld == d2_vld)
        else $error("dividers out of step");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == qrs_pkg::KIND_INVALID |->
            m_tdata == '0 && !m_tuser[2])
        else $error("invalid kind with nonzero result");

    a_double_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == qrs_pkg::KIND_DOUBLE |->
            m_tdata[31:0] == m_tdata[63:32])
        else $error("double root values differ");

    a_imag_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == qrs_pkg::KIND_COMPLEX |-> !m_tdata[63])
        else $error("negative imaginary magnitude");
`endif

endmodule
